[rtl/ost_pkg.sv]
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types and constants for the ordered set table.
// ----------------------------------------------------------------------------
package ost_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int ELEM_W   = 32;
  localparam int OP_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ELEM_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic             success;
    logic [CNT_W-1:0] count;
  } resp_t;

endpackage

[rtl/ost_req_if.sv]
// ----------------------------------------------------------------------------
// ost_req_if
// Request channel: operation code and element value.
// ----------------------------------------------------------------------------
interface ost_req_if import ost_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [ELEM_W-1:0] element;

  modport source (output valid, output operation, output element, input ready);
  modport sink   (input valid, input operation, input element, output ready);
endinterface

[rtl/ost_rsp_if.sv]
// ----------------------------------------------------------------------------
// ost_rsp_if
// Result channel: success flag and element count after the operation.
// ----------------------------------------------------------------------------
interface ost_rsp_if import ost_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             success;
  logic [CNT_W-1:0] count;

  modport source (output valid, output success, output count, input ready);
  modport sink   (input valid, input success, input count, output ready);
endinterface

[rtl/ost_cfg_if.sv]
// ----------------------------------------------------------------------------
// ost_cfg_if
// Configuration write channel for the capacity limit register.
// ----------------------------------------------------------------------------
interface ost_cfg_if import ost_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/ordered_set_table.sv]
// ----------------------------------------------------------------------------
// ordered_set_table
// Set of distinct 32-bit signed integers kept in insertion order.
// ----------------------------------------------------------------------------
// One request at a time: insert, remove or membership test of an element,
// each answered by one result with a success flag and the new count. The
// element memory has a single read port, so the scan compares one stored
// entry per cycle. A remove stops the scan at the match and then shifts
// every entry behind it down one place, one entry per cycle. A result waits
// in the sequencer only while the output register is still held by the
// consumer. The request channel is not ready while an item is in work. The
// capacity limit register (reset 16, held to 16) may be written at any time
// the block is idle; lowering it keeps held entries.
module ordered_set_table import ost_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ost_req_if.sink    req,
  ost_rsp_if.source  rsp,
  ost_cfg_if.sink    cfg
);

  logic [CNT_W-1:0]  limit;
  mem_req_t          mem_req;
  logic [ELEM_W-1:0] rdata;
  resp_t             seq_resp;
  logic              resp_take;
  logic              out_valid;
  logic              out_success;
  logic [CNT_W-1:0]  out_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= CNT_W'(CAPACITY);
    end else if (cfg.valid) begin
      limit <= cfg.data;
    end
  end

  ost_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  ost_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .limit     (limit),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .resp      (seq_resp),
    .resp_take (resp_take)
  );

  // load the output register when it is empty or being drained
  assign resp_take = seq_resp.valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_take) begin
      out_success <= seq_resp.success;
      out_count   <= seq_resp.count;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.success = out_success;
  assign rsp.count   = out_count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seq_resp.valid |-> (seq_resp.count <= CNT_W'(CAPACITY)))
    else $error("count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while an item is in work");

  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !seq_resp.valid)
    else $error("ready while a result is unsent");

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    resp_take |=> rsp.valid)
    else $error("result lost on the way to the output register");

endmodule

[rtl/ost_store.sv]
// ----------------------------------------------------------------------------
// ost_store
// Element memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ost_store import ost_pkg::*; (
  input  logic              clk,
  input  mem_req_t          mem_req,
  output logic [ELEM_W-1:0] rdata
);

  logic [ELEM_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[mem_req.raddr];
  end

endmodule

[rtl/ost_seq.sv]
// ----------------------------------------------------------------------------
// ost_seq
// Sequencer: scans the store with one shared comparator, appends on insert
// and shifts later entries down on remove.
// ----------------------------------------------------------------------------
module ost_seq import ost_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ost_req_if.sink           req,
  input  logic [CNT_W-1:0]  limit,
  output mem_req_t          mem_req,
  input  logic [ELEM_W-1:0] rdata,
  output resp_t             resp,
  input  logic              resp_take
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  rd_idx, rd_idx_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic [OP_W-1:0]   op, op_next;
  logic [ELEM_W-1:0] elem, elem_next;
  logic              ok, ok_next;

  logic [CNT_W-1:0]  eff_limit;
  logic              match;
  logic              issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      pend   <= 1'b0;
      rd_idx <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pend   <= pend_next;
      rd_idx <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    op       <= op_next;
    elem     <= elem_next;
    ok       <= ok_next;
  end

  assign eff_limit = (limit > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : limit;
  // the one comparator, shared by every entry of the scan
  assign match     = pend && (rdata == elem);

  always_comb begin
    state_next    = state;
    count_next    = count;
    rd_idx_next   = rd_idx;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    op_next       = op;
    elem_next     = elem;
    ok_next       = ok;
    issue         = 1'b0;
    mem_req       = '0;
    mem_req.raddr = rd_idx[IDX_W-1:0];
    req.ready     = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_next     = req.operation;
          elem_next   = $unsigned(req.element);
          rd_idx_next = '0;
          pend_next   = 1'b0;
          ok_next     = 1'b0;
          state_next  = S_SCAN;
        end
      end

      S_SCAN: begin
        issue         = !match && (rd_idx < count);
        pend_next     = issue;
        pend_idx_next = rd_idx[IDX_W-1:0];
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        if (match) begin
          pend_next = 1'b0;
          case (op)
            OP_REMOVE: begin
              rd_idx_next = CNT_W'(pend_idx) + 1'b1;
              state_next  = S_SHIFT;
            end
            OP_TEST: begin
              ok_next    = 1'b1;
              state_next = S_RESP;
            end
            default: begin
              ok_next    = 1'b0;
              state_next = S_RESP;
            end
          endcase
        end else if (!pend && !issue) begin
          // scan exhausted: element absent
          if ((op == OP_INSERT) && (count < eff_limit)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = count[IDX_W-1:0];
            mem_req.wdata = elem;
            count_next    = count + 1'b1;
            ok_next       = 1'b1;
          end else begin
            ok_next = 1'b0;
          end
          state_next = S_RESP;
        end
      end

      S_SHIFT: begin
        // read entry j while writing the entry read last cycle, j-1, to j-2
        issue         = (rd_idx < count);
        pend_next     = issue;
        pend_idx_next = rd_idx[IDX_W-1:0];
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        if (pend) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_idx - 1'b1;
          mem_req.wdata = rdata;
        end else if (!issue) begin
          count_next = count - 1'b1;
          ok_next    = 1'b1;
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        if (resp_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign resp.valid   = (state == S_RESP);
  assign resp.success = ok;
  assign resp.count   = count;

endmodule
